// ----- sv/saturating_count_table_rank_select_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the saturating count table
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SATURATING_COUNT_TABLE_RANK_SELECT_DEFINES_SVH
`define SATURATING_COUNT_TABLE_RANK_SELECT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SCTRS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define SCTRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sctrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Saturating count table package
// Sizes, operation codes and kind index helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sctrs_pkg;

  localparam int unsigned Kinds    = 34;
  localparam int unsigned KindIdxW = 6;
  localparam int unsigned CountW   = 3;
  localparam int unsigned TotalW   = 8;
  localparam int unsigned RandW    = 16;

  localparam logic [CountW-1:0] MaxPerKind = 3'd4;
  localparam logic [TotalW-1:0] TotalMax   = 8'd136;

  localparam logic [3:0] SuitSize     = 4'd9;
  localparam logic [3:0] LastSuitSize = 4'd7;
  localparam logic [1:0] LastSuit     = 2'd3;

  localparam logic [2:0] OpAdd    = 3'd0;
  localparam logic [2:0] OpSet    = 3'd1;
  localparam logic [2:0] OpClear  = 3'd2;
  localparam logic [2:0] OpRead   = 3'd3;
  localparam logic [2:0] OpSelect = 3'd4;
  localparam logic [2:0] OpRank   = 3'd5;
  localparam logic [2:0] OpDraw   = 3'd6;

  // First linear index of a suit: suit * 9.
  function automatic logic [KindIdxW-1:0] suit_base(input logic [1:0] s);
    return {1'b0, s, 3'b000} + {4'b0000, s};
  endfunction

  function automatic logic [1:0] kind_suit(input logic [KindIdxW-1:0] i);
    logic [1:0] s;
    if (i >= 6'd27) begin
      s = 2'd3;
    end else if (i >= 6'd18) begin
      s = 2'd2;
    end else if (i >= 6'd9) begin
      s = 2'd1;
    end else begin
      s = 2'd0;
    end
    return s;
  endfunction

  function automatic logic [3:0] kind_number(input logic [KindIdxW-1:0] i);
    logic [KindIdxW-1:0] diff;
    diff = i - suit_base(kind_suit(i));
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/saturating_count_table_rank_select.sv -----
// ----------------------------------------------------------------------------
// Saturating count table with rank and select
// Keeps a 0..4 count for each of 34 kinds and answers add, set, clear, read,
// select by rank, rank of kind and random draw, one beat out per beat in.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Beat contents
// s_axis   in   tuser: operation; tdata: suit, number, delta, new_count,
//               rank_index, random_value
// m_axis   out  tdata: count, total, found, found_suit, found_number, rank
//
// An item goes from its input beat to its result through these steps:
// a read and a write of the addressed entry, then one pass of the shared
// accumulate and compare unit over all 34 counts, one count per cycle from
// the single read port. A draw first runs a 16-step restoring remainder.
// Reset clears the table at once through per-entry valid bits.
// The input is taken again while a result beat still waits on m_axis_tready;
// the next result waits until that beat is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "saturating_count_table_rank_select_defines.svh"

module saturating_count_table_rank_select
  import sctrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // suit[1:0], number[5:2], delta[10:6], new_count[14:11], rank_index[22:15],
  // random_value[38:23], zero[39]
  input  wire logic [39:0] s_axis_tdata,
  // operation[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // count[2:0], total[10:3], found[11], found_suit[13:12], found_number[17:14],
  // rank[25:18], zero[31:26]
  output logic [31:0]      m_axis_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [KindIdxW-1:0] LastKind = KindIdxW'(Kinds - 1);
  localparam logic [KindIdxW-1:0] WalkEnd  = KindIdxW'(Kinds);

  logic [2:0] state_q, state_d;

  // Input fields of the current item.
  logic [1:0]          in_suit;
  logic [3:0]          in_number;
  logic [KindIdxW-1:0] in_idx;
  logic                in_ok;

  logic [2:0]          op_q;
  logic [KindIdxW-1:0] idx_q;
  logic                kind_ok_q;
  logic [4:0]          delta_q;
  logic [3:0]          nc_q;
  logic [TotalW-1:0]   pos_q;
  logic [RandW-1:0]    rv_q;

  // Count memory with per-entry valid bits.
  logic [CountW-1:0]   mem_q [Kinds];
  logic [CountW-1:0]   mem_rd_q;
  logic [Kinds-1:0]    valid_q;
  logic                vld_rd_q;
  logic                rd_en;
  logic [KindIdxW-1:0] rd_addr;
  logic                wr_en;
  logic [CountW-1:0]   wr_data;
  logic [CountW-1:0]   rd_count;

  logic [TotalW-1:0]   total_q, total_d;

  // Remainder unit.
  logic [TotalW-1:0]   rem_q;
  logic [3:0]          div_cnt_q;
  logic [TotalW:0]     trial;
  logic [TotalW-1:0]   rem_next;

  // Walk unit.
  logic [KindIdxW-1:0] walk_q;
  logic                pend_q;
  logic [KindIdxW-1:0] proc_idx_q;
  logic [TotalW-1:0]   acc_q;
  logic [TotalW-1:0]   acc_sum;
  logic                sel_en_q;
  logic                found_q;
  logic [1:0]          fs_q;
  logic [3:0]          fn_q;
  logic [CountW-1:0]   cnt_q;
  logic [TotalW-1:0]   rank_q;

  logic signed [5:0]   add_sum;
  logic [CountW-1:0]   new_count;
  logic                s_beat;

  assign in_suit   = s_axis_tdata[1:0];
  assign in_number = s_axis_tdata[5:2];
  assign in_idx    = suit_base(in_suit) + {2'b00, in_number};
  assign in_ok     = (in_suit == LastSuit) ? (in_number < LastSuitSize)
                                           : (in_number < SuitSize);

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  assign rd_count = vld_rd_q ? mem_rd_q : '0;

  // Saturating update of the addressed entry.
  always_comb begin
    add_sum   = $signed({3'b000, rd_count}) + $signed({delta_q[4], delta_q});
    new_count = rd_count;
    if (op_q == OpAdd) begin
      if (add_sum < 6'sd0) begin
        new_count = '0;
      end else if (add_sum > $signed({3'b000, MaxPerKind})) begin
        new_count = MaxPerKind;
      end else begin
        new_count = add_sum[CountW-1:0];
      end
    end else if (op_q == OpSet) begin
      new_count = ({1'b0, nc_q} > {2'b00, MaxPerKind}) ? MaxPerKind : nc_q[CountW-1:0];
    end
  end

  assign wr_en   = (state_q == S_WR) && kind_ok_q && (op_q == OpAdd || op_q == OpSet);
  assign wr_data = new_count;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    if (state_q == S_RD) begin
      rd_en = kind_ok_q;
    end else if (state_q == S_WALK && walk_q != WalkEnd) begin
      rd_en   = 1'b1;
      rd_addr = walk_q;
    end
  end

  always_comb begin
    total_d = total_q;
    if (op_q == OpClear) begin
      total_d = '0;
    end else if (wr_en) begin
      total_d = total_q - {5'b00000, rd_count} + {5'b00000, new_count};
    end
  end

  assign trial    = {rem_q, rv_q[RandW-1]};
  assign rem_next = (trial >= {1'b0, total_q}) ? TotalW'(trial - {1'b0, total_q})
                                               : trial[TotalW-1:0];
  assign acc_sum  = acc_q + {5'b00000, rd_count};

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (rd_en) begin
        vld_rd_q <= valid_q[rd_addr];
      end
      if (state_q == S_WR && op_q == OpClear) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_beat) state_d = S_RD;
      S_RD:   state_d = S_WR;
      S_WR:   state_d = (op_q == OpDraw && total_d != '0) ? S_MOD : S_WALK;
      S_MOD:  if (div_cnt_q == 4'd15) state_d = S_WALK;
      S_WALK: if (walk_q == WalkEnd && pend_q) state_d = S_DONE;
      S_DONE: if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      total_q       <= '0;
      sel_en_q      <= 1'b0;
      found_q       <= 1'b0;
      pend_q        <= 1'b0;
      walk_q        <= '0;
      div_cnt_q     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready && state_q != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        S_WR: begin
          total_q   <= total_d;
          sel_en_q  <= (op_q == OpSelect) || (op_q == OpDraw && total_d != '0);
          found_q   <= 1'b0;
          walk_q    <= '0;
          pend_q    <= 1'b0;
          div_cnt_q <= '0;
        end
        S_MOD: begin
          div_cnt_q <= div_cnt_q + 4'd1;
        end
        S_WALK: begin
          pend_q <= (walk_q != WalkEnd);
          if (walk_q != WalkEnd) begin
            walk_q <= walk_q + KindIdxW'(1);
          end
          if (pend_q && sel_en_q && !found_q && pos_q < acc_sum) begin
            found_q <= 1'b1;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      op_q      <= s_axis_tuser;
      idx_q     <= in_idx;
      kind_ok_q <= in_ok;
      delta_q   <= s_axis_tdata[10:6];
      nc_q      <= s_axis_tdata[14:11];
      pos_q     <= s_axis_tdata[22:15];
      rv_q      <= s_axis_tdata[38:23];
    end
    if (state_q == S_WR) begin
      acc_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      rank_q <= '0;
      fs_q   <= '0;
      fn_q   <= '0;
    end
    if (state_q == S_MOD) begin
      rem_q <= rem_next;
      rv_q  <= {rv_q[RandW-2:0], 1'b0};
      if (div_cnt_q == 4'd15) begin
        pos_q <= rem_next;
      end
    end
    if (state_q == S_WALK && pend_q) begin
      acc_q <= acc_sum;
      if (kind_ok_q && proc_idx_q == idx_q) begin
        cnt_q  <= rd_count;
        rank_q <= acc_q;
      end
      if (sel_en_q && !found_q && pos_q < acc_sum) begin
        fs_q <= kind_suit(proc_idx_q);
        fn_q <= kind_number(proc_idx_q);
      end
    end
    if (state_q == S_WALK) begin
      proc_idx_q <= (walk_q == WalkEnd) ? LastKind : walk_q;
    end
    if (state_q == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {6'b000000,
                       kind_ok_q ? rank_q : total_q,
                       found_q ? fn_q : 4'd0,
                       found_q ? fs_q : 2'd0,
                       found_q,
                       total_q,
                       cnt_q};
    end
  end

  `SCTRS_ASSERT(a_found_needs_select, !found_q || sel_en_q,
                "found set without a select or draw")
  `SCTRS_ASSERT(a_total_bound, total_q <= TotalMax, "total past its maximum")
  `SCTRS_ASSERT(a_rem_below_total, state_q != S_MOD || rem_q < total_q,
                "remainder not below total")
  `SCTRS_ASSERT_NEXT(a_walk_sum, state_q == S_WALK && state_d == S_DONE,
                     acc_q == total_q, "walk sum differs from running total")

endmodule

`default_nettype wire
